// ===== rtl/sha256h_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256h_pkg
// constants, state encoding and round functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha256h_pkg;

	typedef logic [31:0] word_t;

	localparam word_t IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] FULL_WORD  = 3'd4;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_PAD  = 6'b000100,
		ST_COMP = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_hasher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hasher_unit
// sha-256 over a byte stream given as big-endian words, with built-in padding
// ----------------------------------------------------------------------------
// input channel: word_valid / word_stall with data_word, byte_count, last.
//   byte_count bytes are taken from bits 31..24 downward (5..7 act as 4).
//   bytes are packed one per cycle, outside compression, into a 16-entry block
//   ram, and the next item is taken during the last packing cycle.
// every 64th byte starts the compression: 64 rounds, one per cycle, with the
//   first 16 schedule words read from the block ram through its registered
//   read port, then the fin state folds the working variables into the
//   chaining hash; the round loop limits the average rate of full input items.
// on an item with last set the block appends 0x80, zeros and the 64-bit bit
//   length one byte per cycle, with one or two more compressions, then
//   presents the digest on digest_valid with the four digest_words_* fields.
// output channel: digest_valid / digest_stall; the digest sits in an output
//   register, and while it is stalled the block keeps taking items of the next
//   message; only a second digest waits for the first to be taken.
// reset (arst_n low) loads the initial hash, clears length and fill; no
//   clearing pass is needed, the block ram is always written before its data is used.
module sha256_hasher_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      word_valid,
	output logic                     word_stall,
	input  wire  [31:0]              data_word,
	input  wire  [2:0]               byte_count,
	input  wire                      last,
	output logic                     digest_valid,
	input  wire                      digest_stall,
	output logic [63:0]              digest_words_0_1,
	output logic [63:0]              digest_words_2_3,
	output logic [63:0]              digest_words_4_5,
	output logic [63:0]              digest_words_6_7
);
	import sha256h_pkg::*;

	state_t      state_q;
	logic [5:0]  fill_q;        // bytes held in the current block
	logic [5:0]  round_q;
	logic [63:0] msg_bits_q;    // running message length in bits
	logic [2:0]  cnt_q;         // bytes of the held item still to pack
	logic        last_q;
	logic        pad_start_q;   // 0x80 byte already packed
	logic        len_mode_q;    // now packing length bytes
	logic        fin_blk_q;     // current block holds the length field
	logic        digest_valid_q;
	word_t       hash_q [8];

	word_t       word_q;
	word_t       cur_q;         // partial block word being assembled
	word_t       wv_q [8];      // working variables a..h
	word_t       w_q [16];      // message schedule window
	word_t       rd_data_q;
	word_t       blk_mem [16];
	logic [63:0] dig_q [4];

	logic        accept;
	logic        push_en;
	logic [7:0]  push_byte;
	logic [7:0]  len_byte;
	word_t       merged;
	logic [3:0]  rd_addr;
	word_t       w_new;
	word_t       wt;
	word_t       t1;
	word_t       t2;
	word_t       ch;
	word_t       maj;
	logic        out_free;

	// item intake: idle, or the last packing cycle of a non-final item
	assign word_stall = !((state_q == ST_IDLE) ||
		((state_q == ST_LOAD) && (cnt_q == 3'd1) && !last_q));
	assign accept     = word_valid && !word_stall;
	assign out_free   = !digest_valid_q || !digest_stall;

	// length byte k of the field sits at offset 56 + k, msb first
	assign len_byte = 8'(msg_bits_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		push_en   = 1'b0;
		push_byte = 8'h00;
		case (state_q)
			ST_LOAD: begin
				push_en   = (cnt_q != 3'd0);
				push_byte = word_q[31:24];
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (!pad_start_q) begin
					push_byte = PAD_BYTE;
				end else if (len_mode_q || (fill_q == LEN_OFFSET)) begin
					push_byte = len_byte;
				end else begin
					push_byte = 8'h00;
				end
			end
			default: begin
				push_en   = 1'b0;
				push_byte = 8'h00;
			end
		endcase
	end

	// merge the byte into its lane; lane 0 starts a fresh word
	assign merged = ((fill_q[1:0] == 2'd0) ? 32'h0 : cur_q) |
		(32'(push_byte) << {~fill_q[1:0], 3'b000});

	// schedule words 0..15 come from the ram, one read ahead of the round
	assign rd_addr = (state_q == ST_COMP) ? (round_q[3:0] + 4'd1) : 4'd0;

	// round datapath
	assign w_new = w_q[0] + sml_sig0(w_q[1]) + w_q[9] + sml_sig1(w_q[14]);
	assign wt    = (round_q[5:4] == 2'd0) ? rd_data_q : w_new;
	assign ch    = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj   = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1    = wv_q[7] + big_sig1(wv_q[4]) + ch + K_TAB[round_q] + wt;
	assign t2    = big_sig0(wv_q[0]) + maj;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			round_q        <= '0;
			msg_bits_q     <= '0;
			cnt_q          <= '0;
			last_q         <= 1'b0;
			pad_start_q    <= 1'b0;
			len_mode_q     <= 1'b0;
			fin_blk_q      <= 1'b0;
			digest_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				digest_valid_q <= 1'b1;
			end else if (!digest_stall) begin
				digest_valid_q <= 1'b0;
			end

			if (push_en) begin
				fill_q <= fill_q + 6'd1;
				if (state_q == ST_LOAD) begin
					msg_bits_q <= msg_bits_q + 64'd8;
				end
				if (state_q == ST_PAD) begin
					pad_start_q <= 1'b1;
					if (pad_start_q && (len_mode_q || (fill_q == LEN_OFFSET))) begin
						len_mode_q <= 1'b1;
						if (fill_q == LAST_BYTE) fin_blk_q <= 1'b1;
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (cnt_q == 3'd0) begin
						state_q <= last_q ? ST_PAD : ST_IDLE;
					end else if (fill_q == LAST_BYTE) begin
						state_q <= ST_COMP;
					end else if ((cnt_q == 3'd1) && !accept) begin
						state_q <= last_q ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					if (fill_q == LAST_BYTE) state_q <= ST_COMP;
				end
				ST_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) state_q <= ST_FIN;
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
					if (fin_blk_q) begin
						state_q <= ST_DONE;
					end else if (pad_start_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
						msg_bits_q  <= '0;
						pad_start_q <= 1'b0;
						len_mode_q  <= 1'b0;
						fin_blk_q   <= 1'b0;
						last_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// a newly taken item overrides the count of the one just finished
			if (accept) begin
				cnt_q  <= byte_count[2] ? FULL_WORD : byte_count;
				last_q <= last;
			end else if (push_en && (state_q == ST_LOAD)) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= data_word;
		end else if (push_en && (state_q == ST_LOAD)) begin
			word_q <= {word_q[23:0], 8'h00};
		end

		if (push_en) cur_q <= merged;

		// block complete: start from the chaining hash
		if (push_en && (fill_q == LAST_BYTE)) begin
			for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
		end

		if (state_q == ST_COMP) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wt;
		end

		if ((state_q == ST_DONE) && out_free) begin
			for (int i = 0; i < 4; i++) dig_q[i] <= {hash_q[2 * i], hash_q[2 * i + 1]};
		end
	end

	// block buffer ram, one write and one registered read port
	always_ff @(posedge clk) begin
		if (push_en && (fill_q[1:0] == 2'd3)) blk_mem[fill_q[5:2]] <= merged;
		rd_data_q <= blk_mem[rd_addr];
	end

	assign digest_valid     = digest_valid_q;
	assign digest_words_0_1 = dig_q[0];
	assign digest_words_2_3 = dig_q[1];
	assign digest_words_4_5 = dig_q[2];
	assign digest_words_6_7 = dig_q[3];

`ifndef ASSERT_OFF
	// compression only starts on a full block
	a_comp_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (fill_q == 6'd0))
		else $error("compression running with a partial block");

	// the round loop ends in the hash update
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_COMP) && (round_q == LAST_ROUND)) |=> (state_q == ST_FIN))
		else $error("round loop did not hand over to the hash update");

	// a digest only appears out of the done state
	a_digest_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid_q) |-> $past(state_q == ST_DONE))
		else $error("digest raised outside the done state");

	// a taken item is packed next, unless the byte beside it fills the block
	a_take_pack: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && !word_stall) |=> ((state_q == ST_LOAD) || (state_q == ST_COMP)))
		else $error("item taken but not packed");
`endif

endmodule
`default_nettype wire
